>>> design/ttb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

  // Field widths
  localparam int PosW   = 32;
  localparam int TexW   = 24;
  localparam int UnitW  = 16;

  // Datapath widths
  localparam int EdgeW  = PosW + 1;   // position difference
  localparam int DeltaW = TexW + 1;   // texcoord difference
  localparam int MulW   = 32;         // serial multiplier digit count
  localparam int AccW   = 66;         // product / sum-of-squares accumulator
  localparam int RawW   = 60;         // raw tangent / binormal component
  localparam int NumW   = 47;         // divider numerator
  localparam int CntW   = 6;

  // Normalization window: largest magnitude lands in [2^30, 2^31)
  localparam int NormHi = 31;
  localparam int NormLo = 30;

  localparam int ProdOps   = 14;      // det, tangent and binormal products
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 16;
  localparam int UnitOne   = 16384;

  typedef logic signed [PosW-1:0]   pos_t;
  typedef logic signed [TexW-1:0]   tex_t;
  typedef logic signed [UnitW-1:0]  unit_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [DeltaW-1:0] delta_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [RawW-1:0]   raw_t;
  typedef logic [RawW-1:0]          mag_t;

endpackage

`default_nettype wire

>>> design/ttb_vtx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttb_vtx_if import ttb_pkg::*; ();
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;
  tex_t tex_u;
  tex_t tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

`default_nettype wire

>>> design/ttb_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttb_res_if import ttb_pkg::*; ();
  logic  valid;
  logic  ready;
  unit_t tangent_x;
  unit_t tangent_y;
  unit_t tangent_z;
  unit_t binormal_x;
  unit_t binormal_y;
  unit_t binormal_z;
  logic  degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z,
                  binormal_x, binormal_y, binormal_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z,
                  binormal_x, binormal_y, binormal_z, degenerate, output ready);
endinterface

`default_nettype wire

>>> design/triangle_tangent_binormal.sv
// Per-triangle tangent/binormal unit. Vertices of a triangle list arrive on
// vtx; the first two corners of a triangle are stored, and the third
// starts the computation, after which one result (unit tangent and binormal
// in Q1.14, or zero vectors with degenerate set) appears on res.
// All arithmetic runs through one bit-serial multiply-accumulate, a 2-bit per
// cycle square root and a 1-bit per cycle divider. A third corner occupies
// the block for the products, then per vector for the normalizing shifts,
// the squaring, the square root and the divide steps, most of it in the
// serial multiplier. A zero determinant skips the vector work and ends
// right after the products. The next vertex is accepted while a finished
// result still waits on res.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_binormal
  import ttb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ttb_vtx_if.sink   vtx,
  ttb_res_if.source res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_VEC  = 3'd3;
  localparam logic [2:0] S_NORM = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]      state;
  logic [1:0]      phase;

  // Held corners
  pos_t            hp1 [3];
  pos_t            hp2 [3];
  tex_t            hu1, hv1, hu2, hv2;

  // Edge vectors and texcoord deltas
  edge_t           e1 [3];
  edge_t           e2 [3];
  delta_t          du1, dv1, du2, dv2;

  // Serial MAC
  logic [3:0]      op;
  logic            sqmode;
  logic [1:0]      k;
  logic [CntW-1:0] cnt;
  acc_t            macc, mcand, macc_next, term, op_a;
  logic [MulW-1:0] mplier, op_b;
  logic            msub, op_sub, mneg, clr;

  // Products
  logic            det_neg, det_zero;
  raw_t            tr [3];
  raw_t            br [3];

  // Vector under normalization
  logic            vsel;
  raw_t            vraw [3];
  mag_t            vmag [3];
  mag_t            m [3];
  mag_t            mor;

  // Square root
  logic [63:0]     sn;
  logic [32:0]     srem;
  logic [31:0]     root;
  logic [34:0]     st, strial;
  logic            sbit;

  // Divider
  logic [32:0]     drem;
  logic [15:0]     dnum, dq, dq_next;
  logic [33:0]     dt, dden;
  logic            dbit;
  logic [NumW-1:0] div_num;
  unit_t           qval;

  // Result staging and output register
  unit_t           tv [3];
  unit_t           bv [3];
  logic            deg;
  unit_t           ot [3];
  unit_t           ob [3];
  logic            odeg, ovalid;

  pos_t            in_pos [3];
  logic            in_acc;

  assign in_pos[0] = vtx.pos_x;
  assign in_pos[1] = vtx.pos_y;
  assign in_pos[2] = vtx.pos_z;
  assign vtx.ready = (state == S_IDLE);
  assign in_acc    = vtx.valid && vtx.ready;

  assign res.valid      = ovalid;
  assign res.tangent_x  = ot[0];
  assign res.tangent_y  = ot[1];
  assign res.tangent_z  = ot[2];
  assign res.binormal_x = ob[0];
  assign res.binormal_y = ob[1];
  assign res.binormal_z = ob[2];
  assign res.degenerate = odeg;

  // MAC operand selection
  always_comb begin
    logic [2:0] idx;
    logic [1:0] j;
    logic       odd;
    idx = op[3:1];
    odd = op[0];
    j   = 2'd0;
    if (sqmode) begin
      op_a   = AccW'(m[k]);
      op_b   = m[k][MulW-1:0];
      op_sub = 1'b0;
    end else if (idx == 3'd0) begin
      op_a   = odd ? AccW'(dv1) : AccW'(du1);
      op_b   = odd ? MulW'(du2) : MulW'(dv2);
      op_sub = odd;
    end else if (idx <= 3'd3) begin
      j      = 2'(idx - 3'd1);
      op_a   = odd ? AccW'(e2[j]) : AccW'(e1[j]);
      op_b   = odd ? MulW'(dv1) : MulW'(dv2);
      op_sub = odd;
    end else begin
      j      = 2'(idx - 3'd4);
      op_a   = odd ? AccW'(e1[j]) : AccW'(e2[j]);
      op_b   = odd ? MulW'(du2) : MulW'(du1);
      op_sub = odd;
    end
    clr = sqmode ? (k == 2'd0) : !op[0];
  end

  // One multiplier bit per cycle; the top bit carries negative weight
  always_comb begin
    term      = mplier[0] ? mcand : '0;
    mneg      = (cnt == CntW'(MulW - 1)) ^ msub;
    macc_next = mneg ? macc - term : macc + term;
  end

  // Vector magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vraw[i] = vsel ? br[i] : tr[i];
      vmag[i] = vraw[i][RawW-1] ? mag_t'(-vraw[i]) : mag_t'(vraw[i]);
    end
    mor = m[0] | m[1] | m[2];
  end

  // Square root step
  always_comb begin
    st     = {srem, sn[63:62]};
    strial = {1'b0, root, 2'b01};
    sbit   = (st >= strial);
  end

  // Divider step and signed quotient
  always_comb begin
    div_num = {m[k][30:0], 15'b0} + NumW'(root);
    dt      = {drem, dnum[15]};
    dden    = {root, 1'b0, 1'b0} >> 1;
    dbit    = (dt >= dden);
    dq_next = {dq[14:0], dbit};
    qval    = (vraw[k][RawW-1] ^ det_neg) ? unit_t'(-dq_next) : unit_t'(dq_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= 2'd0;
      ovalid <= 1'b0;
    end else begin
      if (ovalid && res.ready && state != S_OUT) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (phase)
              2'd0: begin
                for (int i = 0; i < 3; i++) hp1[i] <= in_pos[i];
                hu1   <= vtx.tex_u;
                hv1   <= vtx.tex_v;
                phase <= 2'd1;
              end
              2'd1: begin
                for (int i = 0; i < 3; i++) hp2[i] <= in_pos[i];
                hu2   <= vtx.tex_u;
                hv2   <= vtx.tex_v;
                phase <= 2'd2;
              end
              default: begin
                for (int i = 0; i < 3; i++) begin
                  e1[i] <= EdgeW'(hp2[i]) - EdgeW'(hp1[i]);
                  e2[i] <= EdgeW'(in_pos[i]) - EdgeW'(hp1[i]);
                end
                du1    <= DeltaW'(hu2) - DeltaW'(hu1);
                dv1    <= DeltaW'(hv2) - DeltaW'(hv1);
                du2    <= DeltaW'(vtx.tex_u) - DeltaW'(hu1);
                dv2    <= DeltaW'(vtx.tex_v) - DeltaW'(hv1);
                phase  <= 2'd0;
                op     <= 4'd0;
                sqmode <= 1'b0;
                deg    <= 1'b0;
                state  <= S_LOAD;
              end
            endcase
          end
        end

        S_LOAD: begin
          mcand  <= op_a;
          mplier <= op_b;
          msub   <= op_sub;
          cnt    <= '0;
          if (clr) begin
            macc <= '0;
          end
          state <= S_MAC;
        end

        S_MAC: begin
          macc   <= macc_next;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CntW'(MulW - 1)) begin
            if (sqmode) begin
              if (k == 2'd2) begin
                sn    <= macc_next[63:0];
                srem  <= '0;
                root  <= '0;
                cnt   <= '0;
                state <= S_SQRT;
              end else begin
                k     <= k + 1'b1;
                state <= S_LOAD;
              end
            end else begin
              if (op[0]) begin
                if (op[3:1] == 3'd0) begin
                  det_zero <= (macc_next == '0);
                  det_neg  <= macc_next[AccW-1];
                end else if (op[3:1] <= 3'd3) begin
                  tr[2'(op[3:1] - 3'd1)] <= RawW'(macc_next);
                end else begin
                  br[2'(op[3:1] - 3'd4)] <= RawW'(macc_next);
                end
              end
              if (op == 4'(ProdOps - 1)) begin
                if (det_zero) begin
                  deg   <= 1'b1;
                  state <= S_OUT;
                end else begin
                  vsel  <= 1'b0;
                  state <= S_VEC;
                end
              end else begin
                op    <= op + 1'b1;
                state <= S_LOAD;
              end
            end
          end
        end

        S_VEC: begin
          for (int i = 0; i < 3; i++) m[i] <= vmag[i];
          if ((vmag[0] | vmag[1] | vmag[2]) == '0) begin
            deg   <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_NORM;
          end
        end

        // One bit of shift per cycle toward [2^30, 2^31)
        S_NORM: begin
          if (|mor[RawW-1:NormHi]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!mor[NormLo]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            sqmode <= 1'b1;
            k      <= 2'd0;
            state  <= S_LOAD;
          end
        end

        S_SQRT: begin
          sn   <= sn << 2;
          srem <= 33'(sbit ? st - strial : st);
          root <= {root[30:0], sbit};
          cnt  <= cnt + 1'b1;
          if (cnt == CntW'(SqrtSteps - 1)) begin
            k     <= 2'd0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (cnt == '0) begin
            drem <= 33'(div_num >> DivSteps);
            dnum <= div_num[15:0];
            dq   <= '0;
            cnt  <= CntW'(1);
          end else begin
            drem <= 33'(dbit ? dt - dden : dt);
            dnum <= dnum << 1;
            dq   <= dq_next;
            cnt  <= cnt + 1'b1;
            if (cnt == CntW'(DivSteps)) begin
              if (vsel) begin
                bv[k] <= qval;
              end else begin
                tv[k] <= qval;
              end
              cnt <= '0;
              if (k == 2'd2) begin
                if (!vsel) begin
                  vsel  <= 1'b1;
                  state <= S_VEC;
                end else begin
                  state <= S_OUT;
                end
              end else begin
                k <= k + 1'b1;
              end
            end
          end
        end

        S_OUT: begin
          if (!ovalid || res.ready) begin
            for (int i = 0; i < 3; i++) begin
              ot[i] <= deg ? unit_t'(0) : tv[i];
              ob[i] <= deg ? unit_t'(0) : bv[i];
            end
            odeg   <= deg;
            ovalid <= 1'b1;
            state  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Degenerate results carry zero vectors
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (ovalid && odeg) |-> (ot[0] == 0 && ot[1] == 0 && ot[2] == 0 &&
                          ob[0] == 0 && ob[1] == 0 && ob[2] == 0))
    else $error("degenerate result with nonzero vector");

  // Unit components stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (ot[0] <= UnitW'(UnitOne) && ot[0] >= -unit_t'(UnitOne) &&
                ot[1] <= UnitW'(UnitOne) && ot[1] >= -unit_t'(UnitOne) &&
                ot[2] <= UnitW'(UnitOne) && ot[2] >= -unit_t'(UnitOne) &&
                ob[0] <= UnitW'(UnitOne) && ob[0] >= -unit_t'(UnitOne) &&
                ob[1] <= UnitW'(UnitOne) && ob[1] >= -unit_t'(UnitOne) &&
                ob[2] <= UnitW'(UnitOne) && ob[2] >= -unit_t'(UnitOne)))
    else $error("unit component out of range");

  // A third corner starts the product sequence at its first operation
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && phase[1]) |=> (state == S_LOAD && op == 4'd0 && !sqmode))
    else $error("triangle computation did not start");
`endif

endmodule

`default_nettype wire

>>> tb/ttb_checker.sv
`timescale 1ns / 1ps

module ttb_checker
  import ttb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ttb_vtx_if   vtx,
  ttb_res_if   res,
  output int   errors,
  output int   pending
);

  typedef struct {
    unit_t tx, ty, tz;
    unit_t bx, by, bz;
    logic  degen;
  } frame_t;

  frame_t frame_q[$];

  // held corners of the triangle in progress
  pos_t   corner_pos[2][3];
  tex_t   corner_tex[2][2];
  int     corner_idx;

  initial errors = 0;
  assign pending = frame_q.size();

  task automatic report(input string field, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bit_val;
    root = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > n) bit_val >>= 2;
    while (bit_val != 0) begin
      if (n >= root + bit_val) begin
        n -= root + bit_val;
        root = (root >> 1) + bit_val;
      end else begin
        root >>= 1;
      end
      bit_val >>= 2;
    end
    return root;
  endfunction

  // Scale a raw vector to unit length in Q1.14; zero vector gives 0
  function automatic bit unit_scale(input longint v[3], input bit flip, output unit_t o[3]);
    longint unsigned m[3], big, sum, len, q;
    bit neg;
    for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    if (big == 0) return 0;
    while (big >= (64'd1 << NormHi)) begin
      big >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (big < (64'd1 << NormLo)) begin
      big <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (2 * UnitOne * m[i] + len) / (2 * len);
      neg = (v[i] < 0) != flip;
      if (neg) q = -q;
      o[i] = unit_t'(q[UnitW-1:0]);
    end
    return 1;
  endfunction

  // Tangent frame of one triangle from its three corners
  function automatic frame_t tangent_frame(input pos_t p3[3], input tex_t u3, input tex_t v3);
    longint e1[3], e2[3], tr[3], br[3];
    longint du1, dv1, du2, dv2, det;
    unit_t tv[3], bv[3];
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(corner_pos[1][i]) - longint'(corner_pos[0][i]);
      e2[i] = longint'(p3[i]) - longint'(corner_pos[0][i]);
    end
    du1 = longint'(corner_tex[1][0]) - longint'(corner_tex[0][0]);
    dv1 = longint'(corner_tex[1][1]) - longint'(corner_tex[0][1]);
    du2 = longint'(u3) - longint'(corner_tex[0][0]);
    dv2 = longint'(v3) - longint'(corner_tex[0][1]);
    det = du1 * dv2 - dv1 * du2;
    for (int i = 0; i < 3; i++) begin
      tr[i] = dv2 * e1[i] - dv1 * e2[i];
      br[i] = du1 * e2[i] - du2 * e1[i];
    end
    f = '{default: '0};
    if (det == 0 || !unit_scale(tr, det < 0, tv) || !unit_scale(br, det < 0, bv)) begin
      f.degen = 1'b1;
    end else begin
      f.tx = tv[0]; f.ty = tv[1]; f.tz = tv[2];
      f.bx = bv[0]; f.by = bv[1]; f.bz = bv[2];
    end
    return f;
  endfunction

  // Store the first two corners, predict on the third, compare every accepted result
  always @(posedge clk) begin
    pos_t   p[3];
    frame_t want;
    if (rst) begin
      corner_idx <= 0;
    end else begin
      if (vtx.valid && vtx.ready) begin
        p[0] = vtx.pos_x; p[1] = vtx.pos_y; p[2] = vtx.pos_z;
        if (corner_idx < 2) begin
          corner_pos[corner_idx] = p;
          corner_tex[corner_idx][0] = vtx.tex_u;
          corner_tex[corner_idx][1] = vtx.tex_v;
          corner_idx <= corner_idx + 1;
        end else begin
          frame_q = {frame_q, tangent_frame(p, vtx.tex_u, vtx.tex_v)};
          corner_idx <= 0;
        end
      end
      if (res.valid && res.ready) begin
        if (frame_q.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          want = frame_q.pop_front();
          if (res.tangent_x  !== want.tx) report("tangent_x", res.tangent_x, want.tx);
          if (res.tangent_y  !== want.ty) report("tangent_y", res.tangent_y, want.ty);
          if (res.tangent_z  !== want.tz) report("tangent_z", res.tangent_z, want.tz);
          if (res.binormal_x !== want.bx) report("binormal_x", res.binormal_x, want.bx);
          if (res.binormal_y !== want.by) report("binormal_y", res.binormal_y, want.by);
          if (res.binormal_z !== want.bz) report("binormal_z", res.binormal_z, want.bz);
          if (res.degenerate !== want.degen) report("degenerate", res.degenerate, want.degen);
        end
      end
    end
  end

endmodule

>>> tb/triangle_tangent_binormal_tb.sv
`timescale 1ns / 1ps

module triangle_tangent_binormal_tb;
  import ttb_pkg::*;

  localparam int StallLimit = 20000;
  localparam int DrainCycles = 1200;
  localparam int RandTriangles = 510;

  typedef struct {
    pos_t x, y, z;
    tex_t u, v;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   src_idle, snk_idle;
  int   stall_cycles;

  ttb_vtx_if vtx ();
  ttb_res_if res ();

  triangle_tangent_binormal u_dut (.clk(clk), .rst(rst), .vtx(vtx), .res(res));

  ttb_checker u_checker (
    .clk(clk), .rst(rst), .vtx(vtx), .res(res), .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  // Result side backpressure
  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= snk_idle);
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic put_vertex(input vertex_t vx);
    while ($urandom_range(99) < src_idle) begin
      vtx.valid <= 1'b0;
      @(posedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= vx.x;
    vtx.pos_y <= vx.y;
    vtx.pos_z <= vx.z;
    vtx.tex_u <= vx.u;
    vtx.tex_v <= vx.v;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
  endtask

  task automatic put_triangle(input vertex_t a, input vertex_t b, input vertex_t c);
    put_vertex(a);
    put_vertex(b);
    put_vertex(c);
  endtask

  function automatic vertex_t mk(input pos_t x, input pos_t y, input pos_t z,
                                 input tex_t u, input tex_t v);
    vertex_t r;
    r.x = x; r.y = y; r.z = z; r.u = u; r.v = v;
    return r;
  endfunction

  function automatic pos_t pick_pos(input pos_t base);
    pos_t edge_vals[4] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sh1};
    case ($urandom_range(3))
      0: return pos_t'($urandom);
      1: return base + pos_t'($urandom_range(1 << 21)) - pos_t'(1 << 20);
      2: return edge_vals[$urandom_range(3)];
      default: return base + pos_t'($urandom_range(200)) - pos_t'(100);
    endcase
  endfunction

  function automatic tex_t pick_tex(input tex_t base);
    tex_t edge_vals[4] = '{24'sh7fffff, 24'sh800000, 24'sh0, -24'sh1};
    case ($urandom_range(4))
      0: return tex_t'($urandom);
      1: return base + tex_t'($urandom_range(1 << 17)) - tex_t'(1 << 16);
      2: return edge_vals[$urandom_range(3)];
      3: return base;
      default: return base + tex_t'($urandom_range(20)) - tex_t'(10);
    endcase
  endfunction

  function automatic vertex_t near_vertex(input vertex_t base);
    return mk(pick_pos(base.x), pick_pos(base.y), pick_pos(base.z),
              pick_tex(base.u), pick_tex(base.v));
  endfunction

  initial begin
    vertex_t a;
    int tri_idx;
    vtx.valid <= 1'b0;
    vtx.pos_x <= '0;
    vtx.pos_y <= '0;
    vtx.pos_z <= '0;
    vtx.tex_u <= '0;
    vtx.tex_v <= '0;
    src_idle = 10;
    snk_idle = 82;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: plain, flipped determinant, degenerate cases, extremes
    put_triangle(mk(0, 0, 0, 0, 0), mk(32'sh10000, 0, 0, 24'sh10000, 0),
                 mk(0, 32'sh10000, 0, 0, 24'sh10000));
    put_triangle(mk(0, 0, 0, 0, 0), mk(32'sh10000, 0, 0, 0, 24'sh10000),
                 mk(0, 32'sh10000, 0, 24'sh10000, 0));
    put_triangle(mk(5, 6, 7, 24'sh1234, 24'sh1234), mk(-9, 40, 3, 24'sh1234, 24'sh1234),
                 mk(100, -3, 8, 24'sh1234, 24'sh1234));
    put_triangle(mk(77, 77, 77, 0, 0), mk(77, 77, 77, 24'sh100, 0),
                 mk(77, 77, 77, 0, 24'sh100));
    put_triangle(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 24'sh800000, 24'sh800000),
                 mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 24'sh7fffff, 24'sh800000),
                 mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 24'sh800000, 24'sh7fffff));
    put_triangle(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'sh7fffff, 24'sh7fffff),
                 mk(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 24'sh800000, 24'sh7fffff),
                 mk(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 24'sh7fffff, 24'sh800000));
    put_triangle(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0));
    put_triangle(mk(-1, -1, -1, -24'sh1, -24'sh1), mk(1, 2, 3, 24'sh1, 24'sh3),
                 mk(2, 4, 6, 24'sh2, 24'sh1));

    // Random triangles, idle profile changes by thirds
    for (tri_idx = 0; tri_idx < RandTriangles; tri_idx++) begin
      if (tri_idx == RandTriangles / 3) begin
        src_idle = 82;
        snk_idle = 10;
      end else if (tri_idx == 2 * RandTriangles / 3) begin
        src_idle = 0;
        snk_idle = 0;
      end
      a = mk(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
             tex_t'($urandom), tex_t'($urandom));
      if ($urandom_range(1)) begin
        a.x = a.x >>> 8; a.y = a.y >>> 8; a.z = a.z >>> 8;
      end
      put_triangle(a, near_vertex(a), near_vertex(a));
    end
    vtx.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
